>>> hdl/generation_ring_buffer_defines.svh
// assertion macros for the generation ring buffer
// used by the top level only; no other dependencies
`ifndef GENERATION_RING_BUFFER_DEFINES_SVH
`define GENERATION_RING_BUFFER_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GRB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define GRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GRB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/grb_pkg.sv
// shared types and constants for the generation ring buffer
// no dependencies
package grb_pkg;

    localparam int DEPTH_DEF    = 8;
    localparam int MSG_BITS_DEF = 64;
    localparam int GEN_BITS     = 32;
    localparam int DATA_BITS    = 64;

    typedef enum logic {
        OP_PUBLISH = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_EMPTY = 1'b1
    } t_status;

    // per-transaction response bits handed from control to the output stage
    typedef struct packed {
        t_status             status;
        logic                rd_ok;
        logic [GEN_BITS-1:0] next_gen;
    } t_rsp;

endpackage

>>> hdl/grb_mem.sv
// message store: single-port synchronous ram, registered read
// depends on nothing but its parameters
module grb_mem #(
    parameter int DEPTH    = 8,
    parameter int MSG_BITS = 64,
    parameter int IDX_W    = 3
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic                i_re,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [MSG_BITS-1:0] i_wdata,
    output logic [MSG_BITS-1:0] o_rdata
);

    logic [MSG_BITS-1:0] r_mem [DEPTH];
    logic [MSG_BITS-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_idx] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_idx];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> hdl/grb_ctrl.sv
// generation counter, sticky full flag and slot selection
// depends on grb_pkg
module grb_ctrl #(
    parameter int QUEUE_DEPTH = grb_pkg::DEPTH_DEF,
    parameter int IDX_W       = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  grb_pkg::t_op                 i_op,
    input  logic [grb_pkg::GEN_BITS-1:0] i_reader_gen,
    output logic                         o_mem_we,
    output logic                         o_mem_re,
    output logic [IDX_W-1:0]             o_mem_idx,
    output grb_pkg::t_rsp                o_rsp,
    output logic                         o_empty
);
    import grb_pkg::*;

    logic [GEN_BITS-1:0] r_wgen, n_wgen;
    logic                r_full, n_full;
    logic [GEN_BITS-1:0] wg_m1, oldest, rg_a, rg_b;
    logic                in_win, is_pub, is_read;

    assign is_pub  = (i_op == OP_PUBLISH);
    assign is_read = (i_op == OP_READ);
    assign o_empty = (r_wgen == '0) && !r_full;

    // reader slot choice with wraparound-aware window
    always_comb begin
        wg_m1  = r_wgen - GEN_BITS'(1);
        oldest = r_wgen - GEN_BITS'(QUEUE_DEPTH);
        rg_a   = (i_reader_gen == r_wgen) ? wg_m1 : i_reader_gen;
        if (wg_m1 > oldest) begin
            in_win = (rg_a >= oldest) && (rg_a <= wg_m1);
        end else begin
            in_win = (rg_a >= oldest) || (rg_a <= wg_m1);
        end
        if (r_full) begin
            rg_b = in_win ? rg_a : oldest;
        end else begin
            rg_b = (rg_a > r_wgen) ? '0 : rg_a;
        end
    end

    // memory request and response
    always_comb begin
        o_mem_we        = i_accept && is_pub;
        o_mem_re        = i_accept && is_read && !o_empty;
        o_mem_idx       = is_pub ? IDX_W'(r_wgen % GEN_BITS'(QUEUE_DEPTH))
                                 : IDX_W'(rg_b % GEN_BITS'(QUEUE_DEPTH));
        o_rsp.status    = (is_read && o_empty) ? ST_EMPTY : ST_OK;
        o_rsp.rd_ok     = is_read && !o_empty;
        o_rsp.next_gen  = (is_read && !o_empty) ? (rg_b + GEN_BITS'(1)) : i_reader_gen;
    end

    // generation and full flag update on publish
    always_comb begin
        n_wgen = r_wgen;
        n_full = r_full;
        if (i_accept && is_pub) begin
            n_wgen = r_wgen + GEN_BITS'(1);
            if (r_wgen >= GEN_BITS'(QUEUE_DEPTH - 1)) begin
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wgen <= '0;
            r_full <= 1'b0;
        end else begin
            r_wgen <= n_wgen;
            r_full <= n_full;
        end
    end

endmodule

>>> hdl/generation_ring_buffer.sv
// channel  | valid       | stall       | payload
// input    | i_in_valid  | o_in_stall  | i_opcode, i_publish_data, i_reader_generation
// output   | o_out_valid | i_out_stall | o_status, o_read_data, o_next_generation
//
// one transaction per cycle unless the input is stalled; a result appears in the cycle
// after acceptance, from the registered read of the message ram.
// the ram data register doubles as the output register, so a new
// transaction is taken only when the output slot is empty or being drained.
// synchronous active-low reset clears the generation, full flag and output valid;
// the message store is not cleared.
// depends on grb_pkg, grb_ctrl, grb_mem and generation_ring_buffer_defines.svh
`include "generation_ring_buffer_defines.svh"
module generation_ring_buffer #(
    parameter int QUEUE_DEPTH  = grb_pkg::DEPTH_DEF,
    parameter int MESSAGE_BITS = grb_pkg::MSG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [grb_pkg::DATA_BITS-1:0] i_publish_data,
    input  logic [grb_pkg::GEN_BITS-1:0]  i_reader_generation,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_status,
    output logic [grb_pkg::DATA_BITS-1:0] o_read_data,
    output logic [grb_pkg::GEN_BITS-1:0]  o_next_generation
);
    import grb_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                accept;
    logic                mem_we, mem_re, empty;
    logic [IDX_W-1:0]    mem_idx;
    logic [MESSAGE_BITS-1:0] mem_q;
    t_rsp                rsp, r_rsp;
    logic                r_valid, n_valid;
    t_op                 op;

    assign op         = t_op'(i_opcode);
    assign o_in_stall = r_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    grb_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (op),
        .i_reader_gen (i_reader_generation),
        .o_mem_we     (mem_we),
        .o_mem_re     (mem_re),
        .o_mem_idx    (mem_idx),
        .o_rsp        (rsp),
        .o_empty      (empty)
    );

    grb_mem #(
        .DEPTH    (QUEUE_DEPTH),
        .MSG_BITS (MESSAGE_BITS),
        .IDX_W    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_idx   (mem_idx),
        .i_wdata (i_publish_data[MESSAGE_BITS-1:0]),
        .o_rdata (mem_q)
    );

    // output valid
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= rsp;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_status          = r_rsp.status;
    assign o_read_data       = r_rsp.rd_ok ? DATA_BITS'(mem_q) : '0;
    assign o_next_generation = r_rsp.next_gen;

    // checks
    `GRB_ASSERT_NEXT(a_pub_ok, i_clk, i_rst_n, accept && op == OP_PUBLISH, o_out_valid && o_status == ST_OK && o_read_data == '0)
    `GRB_ASSERT_NEXT(a_empty_fail, i_clk, i_rst_n, accept && op == OP_READ && empty, o_out_valid && o_status == ST_EMPTY)
    `GRB_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_status == ST_EMPTY, o_read_data == '0)

endmodule

>>> tb/grb_checker.sv
// reply checker for the generation ring buffer: watches both channels,
// predicts each reply and compares it field by field
// depends on grb_pkg only
`timescale 1ns / 1ps
module grb_checker #(
    parameter int QUEUE_DEPTH  = grb_pkg::DEPTH_DEF,
    parameter int MESSAGE_BITS = grb_pkg::MSG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_opcode,
    input  logic [grb_pkg::DATA_BITS-1:0] i_publish_data,
    input  logic [grb_pkg::GEN_BITS-1:0]  i_reader_generation,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_status,
    input  logic [grb_pkg::DATA_BITS-1:0] i_read_data,
    input  logic [grb_pkg::GEN_BITS-1:0]  i_next_generation,
    output int                            o_pending,
    output int                            o_fail_count
);
    import grb_pkg::*;

    localparam logic [DATA_BITS-1:0] MSG_MASK = {DATA_BITS{1'b1}} >> (DATA_BITS - MESSAGE_BITS);
    localparam logic [GEN_BITS-1:0]  RING_LEN = GEN_BITS'(QUEUE_DEPTH);

    typedef struct {
        t_status              status;
        logic [DATA_BITS-1:0] data;
        logic [GEN_BITS-1:0]  gen;
    } t_reply;

    // shadow copy of the ring and its counters
    logic [DATA_BITS-1:0] shadow_ring [QUEUE_DEPTH];
    logic [GEN_BITS-1:0]  shadow_gen;
    logic                 shadow_full;
    t_reply               awaited_replies [$];
    int                   failures = 0;

    assign o_fail_count = failures;

    function automatic int slot_of(logic [GEN_BITS-1:0] gen);
        return int'(gen % RING_LEN);
    endfunction

    // inclusive window test, allowing the window to wrap past zero
    function automatic logic held(logic [GEN_BITS-1:0] lo, logic [GEN_BITS-1:0] v,
                                  logic [GEN_BITS-1:0] hi);
        if (hi > lo) begin
            return (lo <= v) && (v <= hi);
        end
        return (lo <= v) || (v <= hi);
    endfunction

    // apply one transaction to the shadow state and work out its reply
    function automatic t_reply serve(t_op op, logic [DATA_BITS-1:0] data,
                                     logic [GEN_BITS-1:0] gen);
        t_reply              r;
        logic [GEN_BITS-1:0] pick;
        logic [GEN_BITS-1:0] oldest;
        r.status = ST_OK;
        r.data   = '0;
        r.gen    = gen;
        if (op == OP_PUBLISH) begin
            shadow_ring[slot_of(shadow_gen)] = data & MSG_MASK;
            if (!shadow_full && shadow_gen >= RING_LEN - 1)
                shadow_full = 1'b1;
            shadow_gen = shadow_gen + 1;
            return r;
        end
        // nothing published yet
        if (shadow_gen == '0 && !shadow_full) begin
            r.status = ST_EMPTY;
            return r;
        end
        pick = gen;
        // reader at the head re-reads the newest message
        if (pick == shadow_gen)
            pick = pick - 1;
        if (shadow_full) begin
            oldest = shadow_gen - RING_LEN;
            if (!held(oldest, pick, shadow_gen - 1))
                pick = oldest;
        end else if (pick > shadow_gen) begin
            pick = '0;
        end
        r.data = shadow_ring[slot_of(pick)] & MSG_MASK;
        r.gen  = pick + 1;
        return r;
    endfunction

    task automatic report(string field, logic [DATA_BITS-1:0] want, logic [DATA_BITS-1:0] got);
        $display("%0t: %s expected %h, actual %h", $time, field, want, got);
        failures++;
    endtask

    // compare finished transactions first, then predict newly accepted ones
    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            foreach (shadow_ring[k]) shadow_ring[k] = '0;
            shadow_gen  = '0;
            shadow_full = 1'b0;
            awaited_replies.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected reply, status %0d data %h generation %h",
                             $time, i_status, i_read_data, i_next_generation);
                    failures++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_status !== want.status)
                        report("status", DATA_BITS'(want.status), DATA_BITS'(i_status));
                    if (i_read_data !== want.data)
                        report("read_data", want.data, i_read_data);
                    if (i_next_generation !== want.gen)
                        report("next_generation", DATA_BITS'(want.gen),
                               DATA_BITS'(i_next_generation));
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_replies.push_back(serve(t_op'(i_opcode), i_publish_data,
                                                i_reader_generation));
            o_pending <= awaited_replies.size();
        end
    end

endmodule

>>> tb/testbench.sv
// top of the generation ring buffer testbench: clock, reset, stimulus and verdict
// depends on grb_pkg, generation_ring_buffer and grb_checker
`timescale 1ns / 1ps
module testbench;
    import grb_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 4;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_opcode;
    logic [DATA_BITS-1:0] i_publish_data;
    logic [GEN_BITS-1:0]  i_reader_generation;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_status;
    logic [DATA_BITS-1:0] o_read_data;
    logic [GEN_BITS-1:0]  o_next_generation;

    int                   pending;
    int                   fail_count;
    int                   cycles = 0;
    int                   stall_run;
    logic                 quiet;
    logic [GEN_BITS-1:0]  published;

    always #2 i_clk = ~i_clk;

    generation_ring_buffer #(
        .QUEUE_DEPTH (DEPTH),
        .MESSAGE_BITS(MSG_BITS_DEF)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_publish_data     (i_publish_data),
        .i_reader_generation(i_reader_generation),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_read_data        (o_read_data),
        .o_next_generation  (o_next_generation)
    );

    grb_checker #(
        .QUEUE_DEPTH (DEPTH),
        .MESSAGE_BITS(MSG_BITS_DEF)
    ) reply_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_publish_data     (i_publish_data),
        .i_reader_generation(i_reader_generation),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_status           (o_status),
        .i_read_data        (o_read_data),
        .i_next_generation  (o_next_generation),
        .o_pending          (pending),
        .o_fail_count       (fail_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // reader generations clustered around the held window, plus far-off values
    function automatic logic [GEN_BITS-1:0] reader_gen();
        case ($urandom_range(0, 5))
            0:       return published - GEN_BITS'($urandom_range(0, 2 * DEPTH));
            1:       return published;
            2:       return published + GEN_BITS'($urandom_range(1, 5));
            3:       return GEN_BITS'($urandom);
            4:       return GEN_BITS'($urandom_range(0, 20));
            default: return published - GEN_BITS'($urandom_range(1, DEPTH));
        endcase
    endfunction

    // drive one transaction and hold it until taken
    task automatic push_item(t_op op, logic [DATA_BITS-1:0] data, logic [GEN_BITS-1:0] gen);
        int gap;
        i_in_valid          <= 1'b1;
        i_opcode            <= op;
        i_publish_data      <= data;
        i_reader_generation <= gen;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_PUBLISH)
            published = published + 1;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else if (stall_run > 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= stall_run - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_run   <= pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("generation_ring_buffer: mismatch");
            $finish;
        end
    end

    initial begin
        int phase;
        int k;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_opcode            <= OP_PUBLISH;
        i_publish_data      <= '0;
        i_reader_generation <= '0;
        quiet     = 1'b1;
        published = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reads before anything is published
        push_item(OP_READ, '1, '0);
        push_item(OP_READ, '0, '1);
        // one message: behind, at the head, and ahead of the writer
        push_item(OP_PUBLISH, '0, '1);
        push_item(OP_READ, '0, 32'd0);
        push_item(OP_READ, '0, 32'd1);
        push_item(OP_READ, '0, '1);
        // fill the ring
        push_item(OP_PUBLISH, '1, 32'd0);
        push_item(OP_PUBLISH, {32{2'b10}}, 32'h5555_5555);
        push_item(OP_PUBLISH, {32{2'b01}}, 32'hAAAA_AAAA);
        for (k = 0; k < DEPTH - 4; k++)
            push_item(OP_PUBLISH, {$urandom, $urandom}, GEN_BITS'($urandom));
        // full ring: oldest held, far behind, at the head
        push_item(OP_READ, '0, 32'd0);
        push_item(OP_READ, '0, '1);
        push_item(OP_READ, '0, published);
        // ring wraps over its oldest entry
        push_item(OP_PUBLISH, {$urandom, $urandom}, '0);
        push_item(OP_READ, '0, 32'd0);
        push_item(OP_READ, '0, 32'd100);
        push_item(OP_READ, '1, published - 1);

        // random traffic, one phase without any idling
        for (phase = 0; phase < PHASES; phase++) begin
            quiet = (phase == 1);
            for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
                if ($urandom_range(0, 99) < 45)
                    push_item(OP_PUBLISH, {$urandom, $urandom}, GEN_BITS'($urandom));
                else
                    push_item(OP_READ, {$urandom, $urandom}, reader_gen());
            end
        end
        quiet = 1'b0;

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("generation_ring_buffer: match");
        else
            $display("generation_ring_buffer: mismatch");
        $finish;
    end

endmodule
